// File: design/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg : shared types and constants of the note remap tracking table
// command codes, field widths, controller states and the command / status
// structs that join the controller and the datapath
// ----------------------------------------------------------------------------
package nrt_pkg;

    // field widths of one event
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned CH_W   = 5;
    localparam int unsigned NOTE_W = 7;
    localparam int unsigned VEL_W  = 7;

    // packed slot entry: channel, original note, output note
    localparam int unsigned SLOT_W = CH_W + NOTE_W + NOTE_W;

    // results one note-off may emit, and a counter that can hold that figure
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_ON      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFF     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PENDING = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ON_FIND,
        ST_READ,
        ST_COMPARE,
        ST_FLUSH
    } nrt_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic idx_clr;
        logic idx_inc;
        logic write_slot;
        logic clear_valid;
        logic hold_load;
        logic push_on;
        logic flush;
    } nrt_ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             item_is_off;
        logic             slot_free;
        logic             match;
        logic             idx_last;
        logic             held_valid;
        logic             out_free;
        logic             emit_ok;
        logic             enable;
    } nrt_status_t;

endpackage

// File: design/note_remap_tracking_table.sv
// ----------------------------------------------------------------------------
// note_remap_tracking_table : remembers remapped notes for matching note-offs
// top level joining the controller and the datapath
// ----------------------------------------------------------------------------
// usage
//   s_* carries events: s_tuser is the command (note on, note off, pending
//   removal), s_tdata the channel, original note, output note and velocity.
//   m_* carries emitted note events, m_tlast marks the final result of an
//   event; m_tuser is 1 for a note-off.
//   cfg_wen / cfg_wdata write output_enable; 0 keeps the table updating but
//   emits nothing.
// walk
//   a note-on walks up from slot 0 to the lowest free slot; a note-off or
//   pending removal walks every slot, reading each ram entry in two steps
//   (read, compare); a note-on result enters the output register once its
//   free slot is found and the output register is free; each note-off result
//   waits in a holding register until the next match or the end of the
//   walk, so the last one leaves once the walk is done
// reset
//   all slots are free and output_enable is 0; no ram clearing pass is needed
// stall
//   a stalled receiver holds the walk at the next match; one result waits in
//   the output register while the next is held, so nothing is lost
// ----------------------------------------------------------------------------
module note_remap_tracking_table
    import nrt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel, original_note, note_number, velocity
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_channel, out_note, out_velocity
    output logic        m_tuser,   // out_is_off
    output logic        m_tlast,
    input  logic        cfg_wen,
    input  logic        cfg_wdata
);

    nrt_ctrl_t   ctrl;
    nrt_status_t status;

    // controller
    nrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .status   (status),
        .ctrl     (ctrl)
    );

    // datapath
    nrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    assign s_tready = ctrl.in_ready;

endmodule

// File: design/nrt_ram.sv
// ----------------------------------------------------------------------------
// nrt_ram : generic single-write, single-read ram
// one write port and one read port with the read data registered
// ----------------------------------------------------------------------------
module nrt_ram #(
    parameter int unsigned WIDTH = 19,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/nrt_ctrl.sv
// ----------------------------------------------------------------------------
// nrt_ctrl : controller of the note remap tracking table
// walks the slot table one entry at a time and sequences result transactions
// ----------------------------------------------------------------------------
module nrt_ctrl
    import nrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  nrt_status_t status,
    output nrt_ctrl_t   ctrl
);

    nrt_state_t state_reg;
    nrt_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl.accept  = 1'b1;
                    ctrl.idx_clr = 1'b1;
                    priority if (status.in_cmd == CMD_ON)
                    begin
                        state_next = ST_ON_FIND;
                    end
                    else if (status.in_cmd == CMD_OFF || status.in_cmd == CMD_PENDING)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // lowest free slot takes the note-on
            ST_ON_FIND:
            begin
                if (status.slot_free)
                begin
                    if (!status.enable || status.out_free)
                    begin
                        ctrl.write_slot = 1'b1;
                        ctrl.push_on    = status.enable;
                        state_next      = ST_IDLE;
                    end
                end
                else if (status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                end
            end

            // ram read issued at the current slot
            ST_READ:
            begin
                state_next = ST_COMPARE;
            end

            // compare the slot read back and free it on a match
            ST_COMPARE:
            begin
                if (status.match && status.item_is_off && status.emit_ok)
                begin
                    if (!status.held_valid || status.out_free)
                    begin
                        ctrl.hold_load   = 1'b1;
                        ctrl.clear_valid = 1'b1;
                        ctrl.idx_inc     = !status.idx_last;
                        state_next       = status.idx_last ? ST_FLUSH : ST_READ;
                    end
                end
                else
                begin
                    ctrl.clear_valid = status.match;
                    ctrl.idx_inc     = !status.idx_last;
                    state_next       = status.idx_last ? ST_FLUSH : ST_READ;
                end
            end

            // final held result goes out marked last
            ST_FLUSH:
            begin
                if (!status.held_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    ctrl.flush = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/nrt_datapath.sv
// ----------------------------------------------------------------------------
// nrt_datapath : datapath of the note remap tracking table
// item register, slot index, valid bits, slot ram, held result and output
// register
// ----------------------------------------------------------------------------
module nrt_datapath
    import nrt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  nrt_ctrl_t   ctrl,
    output nrt_status_t status,
    input  logic [1:0]  s_tuser,
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_wen,
    input  logic        cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    // item register
    logic [CMD_W-1:0]  cmd_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [NOTE_W-1:0] orig_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;

    logic [IDX_W-1:0]       idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   enable_reg;
    logic                   held_valid_reg;
    logic [NOTE_W-1:0]      held_note_reg;
    logic [CNT_W-1:0]       count_reg;

    logic              out_valid_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [NOTE_W-1:0] out_note_reg;
    logic [VEL_W-1:0]  out_vel_reg;
    logic              out_off_reg;
    logic              out_last_reg;

    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    logic [CH_W-1:0]   rd_ch;
    logic [NOTE_W-1:0] rd_orig;
    logic [NOTE_W-1:0] rd_note;
    logic              key_match;
    logic              out_free;

    // slot ram, entry packed as channel, original note, output note
    assign ram_wdata = {note_reg, orig_reg, ch_reg};

    nrt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ctrl.write_slot),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_ch   = ram_rdata[CH_W-1:0];
    assign rd_orig = ram_rdata[CH_W+NOTE_W-1:CH_W];
    assign rd_note = ram_rdata[SLOT_W-1:CH_W+NOTE_W];

    // match key depends on the command
    always_comb
    begin
        if (cmd_reg == CMD_OFF)
        begin
            key_match = (rd_orig == orig_reg);
        end
        else
        begin
            key_match = (rd_note == note_reg);
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    // status to the controller
    assign status.in_cmd      = s_tuser;
    assign status.item_is_off = (cmd_reg == CMD_OFF);
    assign status.slot_free   = !valid_reg[idx_reg];
    assign status.match       = valid_reg[idx_reg] && (rd_ch == ch_reg) && key_match;
    assign status.idx_last    = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign status.held_valid  = held_valid_reg;
    assign status.out_free    = out_free;
    assign status.emit_ok     = enable_reg && (count_reg != CNT_W'(MAX_RESULTS));
    assign status.enable      = enable_reg;

    // item capture, payload needs no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg  <= s_tuser;
            ch_reg   <= s_tdata[4:0];
            orig_reg <= s_tdata[11:5];
            note_reg <= s_tdata[18:12];
            vel_reg  <= s_tdata[25:19];
        end
    end

    // slot index, valid bits, held result and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            valid_reg      <= '0;
            enable_reg     <= 1'b0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                enable_reg <= cfg_wdata;
            end
            if (ctrl.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (ctrl.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (ctrl.write_slot)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            else if (ctrl.clear_valid)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (ctrl.accept || ctrl.flush)
            begin
                held_valid_reg <= 1'b0;
            end
            else if (ctrl.hold_load)
            begin
                held_valid_reg <= 1'b1;
            end
            if (ctrl.accept)
            begin
                count_reg <= '0;
            end
            else if (ctrl.hold_load)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // held note of the latest match
    always_ff @(posedge clk)
    begin
        if (ctrl.hold_load)
        begin
            held_note_reg <= rd_note;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.push_on || ctrl.flush || (ctrl.hold_load && held_valid_reg))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload, the three loads never coincide
    always_ff @(posedge clk)
    begin
        if (ctrl.push_on)
        begin
            out_ch_reg   <= ch_reg;
            out_note_reg <= note_reg;
            out_vel_reg  <= vel_reg;
            out_off_reg  <= 1'b0;
            out_last_reg <= 1'b1;
        end
        else if (ctrl.flush)
        begin
            out_ch_reg   <= ch_reg;
            out_note_reg <= held_note_reg;
            out_vel_reg  <= vel_reg;
            out_off_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
        else if (ctrl.hold_load && held_valid_reg)
        begin
            out_ch_reg   <= ch_reg;
            out_note_reg <= held_note_reg;
            out_vel_reg  <= vel_reg;
            out_off_reg  <= 1'b1;
            out_last_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_vel_reg, out_note_reg, out_ch_reg};
    assign m_tuser  = out_off_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: tb/tb_note_remap_tracking_table.sv
// ----------------------------------------------------------------------------
// tb_note_remap_tracking_table : self-checking bench of the note remap table
// note events go in on the s_* stream and a local copy of the slot table
// works out which note events must come out on m_*; each result transaction
// is compared field by field, in order. a short table of directed events comes
// first, then random traffic under four idling mixes and both output settings
// ----------------------------------------------------------------------------
module tb_note_remap_tracking_table
    import nrt_pkg::*;
();

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 1000000;
    // longest walk of the table plus the trip through the output register
    localparam int SETTLE_CYCLES = 2 * DEPTH + 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEMS_PER_SEGMENT = 43;

    // one emitted note event
    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic              is_off;
        logic              last;
    } note_event_t;

    // one row of the directed table; n_exp below zero leaves it to the predictor
    typedef struct {
        logic              set_cfg;
        logic              cfg_val;
        logic [CMD_W-1:0]  cmd;
        logic [CH_W-1:0]   ch;
        logic [NOTE_W-1:0] orig;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        int                n_exp;
        logic [NOTE_W-1:0] first_note;
    } directed_row_t;

    typedef struct {
        logic              typed;
        int                n_exp;
        logic [NOTE_W-1:0] first_note;
    } typed_count_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // channel, original_note, note_number, velocity
    logic [1:0]  s_tuser = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // out_channel, out_note, out_velocity
    logic        m_tuser;        // out_is_off
    logic        m_tlast;
    logic        cfg_wen = 1'b0;
    logic        cfg_wdata = 1'b0;

    // local copy of the slot table and the output switch
    logic              slot_used [DEPTH];
    logic [CH_W-1:0]   slot_chan [DEPTH];
    logic [NOTE_W-1:0] slot_orig [DEPTH];
    logic [NOTE_W-1:0] slot_sent [DEPTH];
    logic              out_enabled = 1'b0;

    note_event_t  remap_results[$];
    typed_count_t typed_counts[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;

    directed_row_t directed_rows[20] = '{
        // output disabled after reset: table changes, nothing sent
        '{1'b0, 1'b0, CMD_ON,      5'd1,   7'd60,  7'd64,  7'd100, 0, 7'd0},
        '{1'b0, 1'b0, CMD_OFF,     5'd1,   7'd60,  7'd0,   7'd0,   0, 7'd0},
        // output enabled: plain on and off with a remapped note
        '{1'b1, 1'b1, CMD_ON,      5'd1,   7'd60,  7'd67,  7'd127, 1, 7'd67},
        '{1'b0, 1'b0, CMD_OFF,     5'd1,   7'd60,  7'd0,   7'd0,   1, 7'd67},
        // note-off with no match
        '{1'b0, 1'b0, CMD_OFF,     5'd1,   7'd60,  7'd0,   7'd1,   0, 7'd0},
        // three slots with one key, freed by one note-off
        '{1'b0, 1'b0, CMD_ON,      5'd16,  7'd127, 7'd127, 7'd127, 1, 7'd127},
        '{1'b0, 1'b0, CMD_ON,      5'd16,  7'd127, 7'd0,   7'd0,   1, 7'd0},
        '{1'b0, 1'b0, CMD_ON,      5'd16,  7'd127, 7'd5,   7'd33,  1, 7'd5},
        '{1'b0, 1'b0, CMD_OFF,     5'd16,  7'd127, 7'd0,   7'd64,  -1, 7'd0},
        // channels outside 1..16
        '{1'b0, 1'b0, CMD_ON,      5'd0,   7'd0,   7'd0,   7'd0,   1, 7'd0},
        '{1'b0, 1'b0, CMD_ON,      5'd31,  7'd0,   7'd99,  7'd85,  1, 7'd99},
        '{1'b0, 1'b0, CMD_OFF,     5'd31,  7'd0,   7'd0,   7'd42,  1, 7'd99},
        // pending removal clears the slot silently
        '{1'b0, 1'b0, CMD_ON,      5'd2,   7'd10,  7'd20,  7'd7,   1, 7'd20},
        '{1'b0, 1'b0, CMD_PENDING, 5'd2,   7'd0,   7'd20,  7'd127, 0, 7'd0},
        '{1'b0, 1'b0, CMD_OFF,     5'd2,   7'd10,  7'd20,  7'd7,   0, 7'd0},
        // unused command is ignored
        '{1'b0, 1'b0, CMD_UNUSED,  5'd31,  7'd127, 7'd127, 7'd127, 0, 7'd0},
        '{1'b0, 1'b0, CMD_PENDING, 5'd0,   7'd0,   7'd0,   7'd0,   0, 7'd0},
        '{1'b0, 1'b0, CMD_ON,      5'd17,  7'd64,  7'd64,  7'd64,  1, 7'd64},
        // note-off while disabled still frees the slot
        '{1'b1, 1'b0, CMD_OFF,     5'd17,  7'd64,  7'd64,  7'd64,  0, 7'd0},
        '{1'b1, 1'b1, CMD_OFF,     5'd17,  7'd64,  7'd64,  7'd64,  0, 7'd0}
    };

    note_remap_tracking_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always #5 clk = ~clk;

    // prints one line per mismatch and counts it
    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // applies one event to the local table and queues the note events it sends
    function automatic void track_event(input logic [CMD_W-1:0] cmd,
                                        input logic [CH_W-1:0] ch,
                                        input logic [NOTE_W-1:0] orig,
                                        input logic [NOTE_W-1:0] note,
                                        input logic [VEL_W-1:0] vel,
                                        output int n,
                                        output logic [NOTE_W-1:0] first);
        note_event_t ev;
        int i;
        n = 0;
        first = '0;
        case (cmd)
            CMD_ON:
            begin
                // lowest free slot, dropped when the table is full
                for (i = 0; i < DEPTH; i++)
                begin
                    if (!slot_used[i])
                    begin
                        slot_used[i] = 1'b1;
                        slot_chan[i] = ch;
                        slot_orig[i] = orig;
                        slot_sent[i] = note;
                        if (out_enabled)
                        begin
                            ev = '{ch, note, vel, 1'b0, 1'b0};
                            remap_results.insert(remap_results.size(), ev);
                            first = note;
                            n = 1;
                        end
                        break;
                    end
                end
            end
            CMD_OFF:
            begin
                for (i = 0; i < DEPTH; i++)
                begin
                    if (slot_used[i] && slot_chan[i] == ch && slot_orig[i] == orig)
                    begin
                        if (out_enabled && n < int'(MAX_RESULTS))
                        begin
                            ev = '{ch, slot_sent[i], vel, 1'b1, 1'b0};
                            remap_results.insert(remap_results.size(), ev);
                            if (n == 0)
                                first = slot_sent[i];
                            n++;
                        end
                        slot_used[i] = 1'b0;
                    end
                end
            end
            CMD_PENDING:
            begin
                for (i = 0; i < DEPTH; i++)
                begin
                    if (slot_used[i] && slot_chan[i] == ch && slot_sent[i] == note)
                        slot_used[i] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (n > 0)
            remap_results[$].last = 1'b1;
    endfunction

    // compares one result transaction with the oldest expected note event
    task automatic check_result();
        note_event_t want;
        if (remap_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result ch %0d note %0d",
                                      m_tdata[4:0], m_tdata[11:5]));
            return;
        end
        want = remap_results.pop_front();
        if (m_tdata[4:0] != want.ch)
            report_mismatch($sformatf("channel %0d, want %0d", m_tdata[4:0], want.ch));
        if (m_tdata[11:5] != want.note)
            report_mismatch($sformatf("note %0d, want %0d", m_tdata[11:5], want.note));
        if (m_tdata[18:12] != want.vel)
            report_mismatch($sformatf("velocity %0d, want %0d", m_tdata[18:12], want.vel));
        if (m_tuser != want.is_off)
            report_mismatch($sformatf("note-off flag %0b, want %0b", m_tuser, want.is_off));
        if (m_tlast != want.last)
            report_mismatch($sformatf("tlast %0b, want %0b", m_tlast, want.last));
    endtask

    // monitor: results first, then config writes and accepted events
    always @(posedge clk)
    begin : monitor
        int n;
        logic [NOTE_W-1:0] first;
        typed_count_t tc;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_wen)
                out_enabled = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                track_event(s_tuser, s_tdata[4:0], s_tdata[11:5], s_tdata[18:12],
                            s_tdata[25:19], n, first);
                // typed counts of the directed rows
                if (typed_counts.size() != 0)
                begin
                    tc = typed_counts.pop_front();
                    if (tc.typed && (n != tc.n_exp || (n > 0 && first != tc.first_note)))
                        report_mismatch($sformatf("directed row gives %0d results, want %0d",
                                                  n, tc.n_exp));
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // sends one event, at times with a random gap ahead of it
    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                              input logic [NOTE_W-1:0] orig, input logic [NOTE_W-1:0] note,
                              input logic [VEL_W-1:0] vel);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, vel, note, orig, ch};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // holds the sender off until every note event is out and the walk is done
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (remap_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_output_enable(input logic en);
        drain();
        cfg_wen <= 1'b1;
        cfg_wdata <= en;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // note-ons sharing one key, then the note-off that frees them all
    task automatic send_burst(input logic [CH_W-1:0] ch, input logic [NOTE_W-1:0] orig,
                              input int n_on, output int sent);
        repeat (n_on)
            send_event(CMD_ON, ch, orig, NOTE_W'($urandom_range(0, 127)),
                       VEL_W'($urandom_range(0, 127)));
        send_event(CMD_OFF, ch, orig, NOTE_W'($urandom_range(0, 127)),
                   VEL_W'($urandom_range(0, 127)));
        sent = n_on + 1;
    endtask

    // a random slot in use, or -1
    function automatic int pick_live_slot();
        int start;
        int i;
        start = $urandom_range(0, DEPTH - 1);
        for (i = 0; i < DEPTH; i++)
        begin
            if (slot_used[(start + i) % DEPTH])
                return (start + i) % DEPTH;
        end
        return -1;
    endfunction

    // channels and original notes mostly from a narrow pool so keys repeat
    function automatic logic [CH_W-1:0] pick_channel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CH_W'($urandom_range(0, 31));
        if (r < 30)
            return CH_W'($urandom_range(1, 16));
        return CH_W'($urandom_range(1, 3));
    endfunction

    function automatic logic [NOTE_W-1:0] pick_orig();
        if ($urandom_range(0, 99) < 20)
            return NOTE_W'($urandom_range(0, 127));
        return NOTE_W'(60 + $urandom_range(0, 3));
    endfunction

    // one random step; counted is the number of events sent
    task automatic random_step(output int counted);
        int r;
        int s;
        logic [CH_W-1:0] ch;
        logic [NOTE_W-1:0] orig;
        r = $urandom_range(0, 99);
        counted = 1;
        ch = pick_channel();
        orig = pick_orig();
        if (r < 4)
            send_burst(ch, orig, int'($urandom_range(2, DEPTH + 2)), counted);
        else if (r < 48)
            send_event(CMD_ON, ch, orig, NOTE_W'($urandom_range(0, 127)),
                       VEL_W'($urandom_range(0, 127)));
        else if (r < 80)
        begin
            s = pick_live_slot();
            if (s >= 0 && $urandom_range(0, 99) < 85)
            begin
                ch = slot_chan[s];
                orig = slot_orig[s];
            end
            send_event(CMD_OFF, ch, orig, NOTE_W'($urandom_range(0, 127)),
                       VEL_W'($urandom_range(0, 127)));
        end
        else if (r < 94)
        begin
            s = pick_live_slot();
            if (s >= 0 && $urandom_range(0, 99) < 85)
                send_event(CMD_PENDING, slot_chan[s], NOTE_W'($urandom_range(0, 127)),
                           slot_sent[s], VEL_W'($urandom_range(0, 127)));
            else
                send_event(CMD_PENDING, ch, orig, NOTE_W'($urandom_range(0, 127)),
                           VEL_W'($urandom_range(0, 127)));
        end
        else
        begin
            // noise the block ignores
            send_event(CMD_UNUSED, CH_W'($urandom_range(0, 31)),
                       NOTE_W'($urandom_range(0, 127)), NOTE_W'($urandom_range(0, 127)),
                       VEL_W'($urandom_range(0, 127)));
        end
    endtask

    // stimulus
    initial
    begin
        typed_count_t tc;
        int phase;
        int seg;
        int count;
        int got;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].set_cfg)
                set_output_enable(directed_rows[k].cfg_val);
            tc.typed = (directed_rows[k].n_exp >= 0);
            tc.n_exp = directed_rows[k].n_exp;
            tc.first_note = directed_rows[k].first_note;
            typed_counts.insert(typed_counts.size(), tc);
            send_event(directed_rows[k].cmd, directed_rows[k].ch, directed_rows[k].orig,
                       directed_rows[k].note, directed_rows[k].vel);
        end

        // random traffic under each idling mix, output switched per segment
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            for (seg = 0; seg < 2; seg++)
            begin
                set_output_enable(!(phase == 1 && seg == 1));
                count = 0;
                // fill the table past full, then free every slot at once
                if (phase == 0 && seg == 0)
                    send_burst(pick_channel(), pick_orig(), DEPTH + 1, count);
                while (count < ITEMS_PER_SEGMENT)
                begin
                    random_step(got);
                    count += got;
                end
            end
        end

        drain();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
